>>> rtl/abst_pkg.sv
// Shared types and constants for the implicit-array binary search tree block.
// No dependencies; every other file of the block but abst_ram imports this package.
package abst_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int IN_KEY_W      = 32;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = 10;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic                       cmd;
    logic signed [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

>>> rtl/abst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module abst_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/abst_cmp.sv
// Shared key comparator used once per tree level by the walk sequencer.
// Depends on abst_pkg for the compare result type.
module abst_cmp #(
  parameter int KEY_WIDTH = abst_pkg::KEY_WIDTH_DEF
) (
  input  logic signed [KEY_WIDTH-1:0] stored_key,
  input  logic signed [KEY_WIDTH-1:0] want_key,
  output abst_pkg::cmp_res_t          res
);
  import abst_pkg::*;

  // Two's complement order of the keys.
  assign res.eq = (stored_key == want_key);
  assign res.gt = (stored_key > want_key);

endmodule

>>> rtl/abst_walk.sv
// Walk sequencer: clears the slot store after reset, then walks the tree one level per cycle.
// Depends on abst_pkg; drives the slot RAM and the shared comparator from the top level.
module abst_walk #(
  parameter int MAX_NODES = abst_pkg::MAX_NODES_DEF,
  parameter int KEY_WIDTH = abst_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  abst_pkg::in_item_t               in_data,
  output logic                             ram_we,
  output logic [$clog2(MAX_NODES)-1:0]     ram_waddr,
  output logic [KEY_WIDTH:0]               ram_wdata,
  output logic [$clog2(MAX_NODES)-1:0]     ram_raddr,
  input  logic [KEY_WIDTH:0]               ram_rdata,
  output logic signed [KEY_WIDTH-1:0]      cmp_stored,
  output logic signed [KEY_WIDTH-1:0]      cmp_want,
  input  abst_pkg::cmp_res_t               cmp_res,
  output logic                             res_valid,
  output abst_pkg::out_item_t              res_data,
  input  logic                             res_take
);
  import abst_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int IW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        cmd_r, cmd_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  out_item_t                   res_r, res_nxt;

  logic                        stored_valid;
  logic [IW-1:0]               child_idx;
  logic                        past_end;

  assign stored_valid = ram_rdata[KEY_WIDTH];
  assign cmp_stored   = ram_rdata[KEY_WIDTH-1:0];
  assign cmp_want     = key_r;

  // Left child when the stored key is greater, right child otherwise.
  assign child_idx = {idx_r[IW-2:0], ~cmp_res.gt};
  assign past_end  = (child_idx >= IW'(MAX_NODES));

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    idx_nxt     = idx_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = '0;
    ram_raddr   = AW'(1);
    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          key_nxt   = KEY_WIDTH'(in_data.key);
          idx_nxt   = IW'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        priority if (!stored_valid) begin
          if (cmd_r == CMD_INSERT) begin
            ram_we         = 1'b1;
            ram_waddr      = idx_r[AW-1:0];
            ram_wdata      = {1'b1, key_r};
            res_nxt.status = ST_INSERTED;
            res_nxt.slot   = SLOT_W'(idx_r);
          end else begin
            res_nxt.status = ST_NOT_FOUND;
            res_nxt.slot   = '0;
          end
          state_nxt = S_DONE;
        end else if (cmp_res.eq) begin
          res_nxt.status = (cmd_r == CMD_INSERT) ? ST_DUPLICATE : ST_FOUND;
          res_nxt.slot   = SLOT_W'(idx_r);
          state_nxt      = S_DONE;
        end else if (past_end) begin
          res_nxt.status = (cmd_r == CMD_INSERT) ? ST_NO_ROOM : ST_NOT_FOUND;
          res_nxt.slot   = '0;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = child_idx;
          ram_raddr = child_idx[AW-1:0];
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/array_bst_insert_search_top.sv
// Implicit-array binary search tree: insert or search one key per item.
// An item is accepted, walks the tree one level per slot-RAM read, is handed off, then sits in
// the output register; the walk ends at an empty slot, an equal key or past the last slot.
// One item at a time: a new item is accepted only after the previous result is handed off.
// Reset (rst_n, synchronous, active low) then clears every slot-RAM word, in_stall high.
module array_bst_insert_search_top #(
  parameter int MAX_NODES = abst_pkg::MAX_NODES_DEF,
  parameter int KEY_WIDTH = abst_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  abst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output abst_pkg::out_item_t out_data
);
  import abst_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  // Each RAM word holds an occupancy bit above the stored key, so every key value can be
  // stored and a cleared word reads as an empty slot.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [KEY_WIDTH:0]          ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [KEY_WIDTH:0]          ram_rdata;

  logic signed [KEY_WIDTH-1:0] cmp_stored;
  logic signed [KEY_WIDTH-1:0] cmp_want;
  cmp_res_t                    cmp_res;

  logic                        res_valid;
  out_item_t                   res_data;
  logic                        res_take;

  logic                        out_valid_r;
  out_item_t                   out_data_r;

  abst_ram #(
    .WIDTH (KEY_WIDTH + 1),
    .DEPTH (MAX_NODES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  abst_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .stored_key (cmp_stored),
    .want_key   (cmp_want),
    .res        (cmp_res)
  );

  abst_walk #(
    .MAX_NODES (MAX_NODES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .cmp_stored (cmp_stored),
    .cmp_want   (cmp_want),
    .cmp_res    (cmp_res),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_take   (res_take)
  );

  // The output register separates the walk from the downstream stall, so the sequencer can
  // go back to accepting an item while the previous result still waits to be taken.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item keeps the walk busy for at least the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an accept");

  // A pending result and readiness for a new item never coincide.
  a_result_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && !in_stall))
    else $error("walk ready while a result is pending");

  // A handed-off result shows up on the output in the next cycle.
  a_handoff : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid)
    else $error("handed-off result missing at the output");

  // Misses and full-tree outcomes carry no slot.
  a_miss_slot_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_ROOM || out_data.status == ST_NOT_FOUND)
    |-> out_data.slot == '0)
    else $error("nonzero slot on a miss");

endmodule
